### rtl/pbx_pkg.sv
// Shared types and constants for the protobuf data field extractor.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps
`default_nettype none

package pbx_pkg;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_TAG    = 5'b00001,
    PH_VARINT = 5'b00010,
    PH_LENGTH = 5'b00100,
    PH_SKIP   = 5'b01000,
    PH_HALT   = 5'b10000
  } phase_t;

  // Wire types handled by the parser
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  // Field numbers of interest
  localparam logic [4:0] FIELD_PORT    = 5'd1;
  localparam logic [4:0] FIELD_PAYLOAD = 5'd2;

  localparam int unsigned ACC_W = 32;

  localparam logic [8:0] SKIP_FIXED32 = 9'd4;
  localparam logic [8:0] SKIP_FIXED64 = 9'd8;
  localparam logic [6:0] SHIFT_STEP   = 7'd7;
  localparam logic [5:0] SHIFT_MAX    = 6'd63;
  localparam logic [5:0] SHIFT_LIMIT  = 6'd32;

  // One input byte with its message length
  typedef struct packed {
    logic [8:0] message_length;
    logic [7:0] data_byte;
  } item_t;

  // One per-message result
  typedef struct packed {
    logic [7:0] payload_length;
    logic [7:0] payload_offset;
    logic [7:0] port_number;
    logic       found;
  } result_t;

endpackage

`default_nettype wire

### rtl/pbx_in_stage.sv
// Input register stage of the extractor: captures one request per cycle while in_tready is high.
// Depends on pbx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbx_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [23:0]    in_tdata,
  input  wire logic           advance,   // downstream consumes the held item
  output logic                item_valid,
  output pbx_pkg::item_t      item
);

  logic           valid_r;
  pbx_pkg::item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte      <= in_tdata[7:0];
      item_r.message_length <= in_tdata[16:8];
    end
  end

endmodule

`default_nettype wire

### rtl/pbx_parser.sv
// Parser state and combinational byte step of the extractor.
// Depends on pbx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbx_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step_en,
  input  pbx_pkg::item_t      item,
  output logic                res_valid,
  output pbx_pkg::result_t    res
);

  pbx_pkg::phase_t            phase_r, phase_nxt;
  logic [4:0]                 field_r, field_nxt;
  logic [pbx_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [5:0]                 shift_r, shift_nxt;
  logic [8:0]                 skip_r, skip_nxt;
  logic [8:0]                 pos_r, pos_nxt;
  logic [7:0]                 port_r, port_nxt;
  logic [7:0]                 offset_r, offset_nxt;
  logic [7:0]                 length_r, length_nxt;
  logic                       found_r, found_nxt;

  logic [7:0]                 b;
  logic [8:0]                 len_c;
  logic [9:0]                 p1;
  logic                       last;
  logic [8:0]                 rem;
  logic [pbx_pkg::ACC_W-1:0]  rem_ext;
  logic [pbx_pkg::ACC_W-1:0]  add_bits;
  logic [pbx_pkg::ACC_W-1:0]  acc_abs;
  logic [6:0]                 shift_inc;
  logic [5:0]                 shift_abs;
  logic                       fin;
  logic                       tail_found;

  assign b = item.data_byte;

  // clamp length into 1..MAX
  always_comb begin
    if (32'(item.message_length) > 32'(MAX_MESSAGE_BYTES)) begin
      len_c = 9'(MAX_MESSAGE_BYTES);
    end else if (item.message_length == 9'd0) begin
      len_c = 9'd1;
    end else begin
      len_c = item.message_length;
    end
  end

  assign p1      = {1'b0, pos_r} + 10'd1;
  assign last    = (p1 >= {1'b0, len_c});
  assign rem     = last ? 9'd0 : 9'({1'b0, len_c} - p1);
  assign rem_ext = {{(pbx_pkg::ACC_W-9){1'b0}}, rem};

  // varint absorb: bits at shift 32 and up are dropped
  assign add_bits  = (shift_r < pbx_pkg::SHIFT_LIMIT)
                   ? ({{(pbx_pkg::ACC_W-7){1'b0}}, b[6:0]} << shift_r[4:0])
                   : '0;
  assign acc_abs   = acc_r | add_bits;
  assign shift_inc = {1'b0, shift_r} + pbx_pkg::SHIFT_STEP;
  assign shift_abs = (shift_inc > {1'b0, pbx_pkg::SHIFT_MAX}) ? pbx_pkg::SHIFT_MAX
                                                              : shift_inc[5:0];
  assign fin       = !b[7];

  always_comb begin
    phase_nxt  = phase_r;
    field_nxt  = field_r;
    acc_nxt    = acc_r;
    shift_nxt  = shift_r;
    skip_nxt   = skip_r;
    port_nxt   = port_r;
    offset_nxt = offset_r;
    length_nxt = length_r;
    found_nxt  = found_r;
    pos_nxt    = p1[8:0];

    case (phase_r)
      pbx_pkg::PH_TAG: begin
        field_nxt = b[7:3];
        acc_nxt   = '0;
        shift_nxt = '0;
        case (b[2:0])
          pbx_pkg::WIRE_VARINT: phase_nxt = pbx_pkg::PH_VARINT;
          pbx_pkg::WIRE_LEN:    phase_nxt = pbx_pkg::PH_LENGTH;
          pbx_pkg::WIRE_FIXED32: begin
            phase_nxt = pbx_pkg::PH_SKIP;
            skip_nxt  = pbx_pkg::SKIP_FIXED32;
          end
          pbx_pkg::WIRE_FIXED64: begin
            phase_nxt = pbx_pkg::PH_SKIP;
            skip_nxt  = pbx_pkg::SKIP_FIXED64;
          end
          default: phase_nxt = pbx_pkg::PH_HALT;
        endcase
      end
      pbx_pkg::PH_VARINT: begin
        acc_nxt = acc_abs;
        if (fin) begin
          if (field_r == pbx_pkg::FIELD_PORT) begin
            port_nxt = acc_abs[7:0];
          end
          phase_nxt = pbx_pkg::PH_TAG;
        end else begin
          shift_nxt = shift_abs;
        end
      end
      pbx_pkg::PH_LENGTH: begin
        acc_nxt = acc_abs;
        if (fin) begin
          if (field_r == pbx_pkg::FIELD_PAYLOAD && acc_abs <= rem_ext) begin
            found_nxt  = 1'b1;
            offset_nxt = p1[7:0];
            length_nxt = acc_abs[7:0];
          end
          if (acc_abs == '0) begin
            phase_nxt = pbx_pkg::PH_TAG;
          end else begin
            phase_nxt = pbx_pkg::PH_SKIP;
            skip_nxt  = (acc_abs < rem_ext) ? acc_abs[8:0] : rem;
          end
        end else begin
          shift_nxt = shift_abs;
        end
      end
      pbx_pkg::PH_SKIP: begin
        if (skip_r <= 9'd1) begin
          skip_nxt  = 9'd0;
          phase_nxt = pbx_pkg::PH_TAG;
        end else begin
          skip_nxt = skip_r - 9'd1;
        end
      end
      default: begin
        // halted: consume bytes without effect
      end
    endcase
  end

  // end-of-message fixups for fields cut off by the message end
  assign tail_found = (phase_nxt == pbx_pkg::PH_LENGTH) &&
                      (field_nxt == pbx_pkg::FIELD_PAYLOAD) &&
                      (shift_nxt != 6'd0) && (acc_nxt == '0);

  always_comb begin
    res.found          = found_nxt || tail_found;
    res.port_number    = ((phase_nxt == pbx_pkg::PH_VARINT) &&
                          (field_nxt == pbx_pkg::FIELD_PORT)) ? acc_nxt[7:0] : port_nxt;
    if (tail_found) begin
      res.payload_offset = len_c[7:0];
      res.payload_length = 8'd0;
    end else if (found_nxt) begin
      res.payload_offset = offset_nxt;
      res.payload_length = length_nxt;
    end else begin
      res.payload_offset = 8'd0;
      res.payload_length = 8'd0;
    end
  end

  assign res_valid = step_en && last;

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && last)) begin
      phase_r  <= pbx_pkg::PH_TAG;
      field_r  <= '0;
      acc_r    <= '0;
      shift_r  <= '0;
      skip_r   <= '0;
      pos_r    <= '0;
      port_r   <= '0;
      offset_r <= '0;
      length_r <= '0;
      found_r  <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      field_r  <= field_nxt;
      acc_r    <= acc_nxt;
      shift_r  <= shift_nxt;
      skip_r   <= skip_nxt;
      pos_r    <= pos_nxt;
      port_r   <= port_nxt;
      offset_r <= offset_nxt;
      length_r <= length_nxt;
      found_r  <= found_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/protobuf_data_field_extractor.sv
// Top level of the protobuf data field extractor: input stage, parser, result register.
// Depends on pbx_pkg, pbx_in_stage and pbx_parser.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   in_*  : one request per message byte. tdata carries data_byte and
//           message_length (same value for every byte of a message).
//   out_* : one request per message, issued for the last byte. tdata carries
//           found, port_number, payload_offset and payload_length.
//   Tags are single-byte; field 1 varint gives the port, the last field 2
//   length-delimited field that fits gives offset/length. Unknown wire types
//   stop parsing until the message ends.
// Timing: the edge that accepts the last byte loads the input register; the
//   parser steps on that byte and writes the result register at the first
//   later edge on which advance is high, and out_tvalid rises with it.
// Throughput: 1 byte per cycle while the result register can take a result;
//   the parser updates its state once per byte, so bytes stream back to back.
// Stall: while a result waits with out_tready low, the byte in the input
//   register is held whatever it is; in_tready drops once the input register
//   is full and the result register cannot drain.
// Reset: synchronous, active low; parser returns to expecting a tag at
//   message byte 0 and both registers empty. Parser state also returns to
//   that point after every message.
module protobuf_data_field_extractor #(
  parameter int unsigned MAX_MESSAGE_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] data_byte, [16:8] message_length
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [0] found, [8:1] port_number,
                                       // [16:9] payload_offset, [24:17] payload_length
);

  logic             advance;
  logic             s1_valid;
  pbx_pkg::item_t   s1_item;
  logic             res_valid;
  pbx_pkg::result_t res;

  logic             out_valid_r;
  pbx_pkg::result_t out_data_r;

  // the held byte moves on whenever the result register can take a result
  assign advance = !out_valid_r || out_tready;

  pbx_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  pbx_parser #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_valid && advance),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

  // an empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("in_tready low with empty result register");

  // no result right after reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a new result must come from a byte held in the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid))
    else $error("result appeared without an input byte");

  // without a payload, offset and length read zero
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_data_r.found) |->
      (out_data_r.payload_offset == 8'd0 && out_data_r.payload_length == 8'd0))
    else $error("offset/length nonzero without payload");

endmodule

`default_nettype wire

### bench/pbx_result_checker.sv
// Result checker for the protobuf data field extractor: follows every accepted byte
// with its own parser and compares each result request against the oldest prediction.
// Depends on pbx_pkg (item and result layouts, wire types, field numbers).
`timescale 1ns / 1ps

module pbx_result_checker #(
  parameter int unsigned MAX_MESSAGE_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] data_byte, [16:8] message_length
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // [0] found, [8:1] port_number,
                                       // [16:9] payload_offset, [24:17] payload_length
  output int               mismatch_count,
  output int               pending_results,
  output int               results_checked,
  output int               payloads_found
);

  typedef enum logic [2:0] {
    AWAIT_TAG,
    IN_VARINT,
    IN_LENGTH,
    SKIPPING,
    HALTED
  } parse_state_t;

  localparam int unsigned ACC_BITS      = 32;
  localparam int unsigned SHIFT_CEILING = 63;
  localparam logic [8:0]  FIXED32_BYTES = 9'd4;
  localparam logic [8:0]  FIXED64_BYTES = 9'd8;

  parse_state_t state;
  logic [4:0]   field_id;
  logic [31:0]  accum;
  logic [5:0]   shift;
  logic [8:0]   skip_left;
  logic [8:0]   position;
  logic [7:0]   port_q;
  logic [7:0]   offset_q;
  logic [7:0]   length_q;
  logic         found_q;

  pbx_pkg::result_t expected_results[$];

  int errors  = 0;
  int checked = 0;
  int located = 0;

  function automatic void clear_parser();
    state     = AWAIT_TAG;
    field_id  = '0;
    accum     = '0;
    shift     = '0;
    skip_left = '0;
    position  = '0;
    port_q    = '0;
    offset_q  = '0;
    length_q  = '0;
    found_q   = 1'b0;
  endfunction

  // One varint byte into the accumulator; high bits past 32 drop out.
  function automatic bit absorb_varint_byte(input logic [7:0] b);
    int unsigned next_shift;
    if (shift < ACC_BITS) accum = accum | (32'(b[6:0]) << shift);
    if (!b[7]) return 1'b1;
    next_shift = shift + 7;
    shift = (next_shift > SHIFT_CEILING) ? 6'(SHIFT_CEILING) : 6'(next_shift);
    return 1'b0;
  endfunction

  function automatic void advance_parser(input pbx_pkg::item_t req);
    int unsigned      msg_len;
    int unsigned      next_pos;
    int unsigned      remaining;
    bit               at_end;
    pbx_pkg::result_t r;
    msg_len = req.message_length;
    if (msg_len > MAX_MESSAGE_BYTES) msg_len = MAX_MESSAGE_BYTES;
    if (msg_len == 0) msg_len = 1;
    next_pos  = position + 1;
    at_end    = (next_pos >= msg_len);
    remaining = at_end ? 0 : msg_len - next_pos;

    case (state)
      AWAIT_TAG: begin
        field_id = req.data_byte[7:3];
        accum    = '0;
        shift    = '0;
        case (req.data_byte[2:0])
          pbx_pkg::WIRE_VARINT: state = IN_VARINT;
          pbx_pkg::WIRE_LEN:    state = IN_LENGTH;
          pbx_pkg::WIRE_FIXED32: begin
            state     = SKIPPING;
            skip_left = FIXED32_BYTES;
          end
          pbx_pkg::WIRE_FIXED64: begin
            state     = SKIPPING;
            skip_left = FIXED64_BYTES;
          end
          default: state = HALTED;
        endcase
      end
      IN_VARINT: begin
        if (absorb_varint_byte(req.data_byte)) begin
          if (field_id == pbx_pkg::FIELD_PORT) port_q = accum[7:0];
          state = AWAIT_TAG;
        end
      end
      IN_LENGTH: begin
        if (absorb_varint_byte(req.data_byte)) begin
          // payload only counts when it fits before the message end
          if (field_id == pbx_pkg::FIELD_PAYLOAD && accum <= remaining) begin
            found_q  = 1'b1;
            offset_q = 8'(next_pos);
            length_q = accum[7:0];
          end
          if (accum == 0) begin
            state = AWAIT_TAG;
          end else begin
            state     = SKIPPING;
            skip_left = (accum < remaining) ? 9'(accum) : 9'(remaining);
          end
        end
      end
      SKIPPING: begin
        if (skip_left <= 1) begin
          skip_left = '0;
          state     = AWAIT_TAG;
        end else begin
          skip_left = skip_left - 1;
        end
      end
      default: ;
    endcase
    position = 9'(next_pos);

    if (at_end) begin
      // unfinished port varint still counts; unfinished zero length finds an empty payload
      if (state == IN_VARINT && field_id == pbx_pkg::FIELD_PORT) port_q = accum[7:0];
      if (state == IN_LENGTH && field_id == pbx_pkg::FIELD_PAYLOAD &&
          shift != 0 && accum == 0) begin
        found_q  = 1'b1;
        offset_q = 8'(msg_len);
        length_q = '0;
      end
      r.found          = found_q;
      r.port_number    = port_q;
      r.payload_offset = found_q ? offset_q : 8'd0;
      r.payload_length = found_q ? length_q : 8'd0;
      expected_results.push_back(r);
      clear_parser();
    end
  endfunction

  always @(posedge clk) begin : watch
    pbx_pkg::result_t got;
    pbx_pkg::result_t want;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) advance_parser(pbx_pkg::item_t'(in_tdata[16:0]));
      if (out_tvalid && out_tready) begin
        got = pbx_pkg::result_t'(out_tdata[24:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual found=%0d port=%0d offset=%0d length=%0d",
                   $time, got.found, got.port_number, got.payload_offset, got.payload_length);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            errors++;
          end
          if (got.port_number !== want.port_number) begin
            $display("%0t: port_number expected %0d actual %0d",
                     $time, want.port_number, got.port_number);
            errors++;
          end
          if (got.payload_offset !== want.payload_offset) begin
            $display("%0t: payload_offset expected %0d actual %0d",
                     $time, want.payload_offset, got.payload_offset);
            errors++;
          end
          if (got.payload_length !== want.payload_length) begin
            $display("%0t: payload_length expected %0d actual %0d",
                     $time, want.payload_length, got.payload_length);
            errors++;
          end
          checked++;
          if (want.found) located++;
        end
      end
    end
    mismatch_count  <= errors;
    pending_results <= expected_results.size();
    results_checked <= checked;
    payloads_found  <= located;
  end

endmodule

### bench/testbench.sv
// Top of the bench for protobuf_data_field_extractor: clock, reset, byte stimulus,
// output back-pressure and the final verdict. Depends on pbx_pkg, the block and
// pbx_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MSG_MAX         = 256;
  localparam int          ITEM_TARGET     = 1150;
  localparam int          QUIET_TAIL      = 150;    // last bytes go without any idling
  localparam int          PRESSURE_CYCLES = 400;
  localparam int          TAIL_CYCLES     = 20;
  localparam int          CYCLE_LIMIT     = 400000;

  // wire types that make the parser stop for the rest of the message
  localparam logic [2:0] WIRE_GROUP_START = 3'd3;
  localparam logic [2:0] WIRE_GROUP_END   = 3'd4;
  localparam logic [2:0] WIRE_RESERVED_6  = 3'd6;
  localparam logic [2:0] WIRE_RESERVED_7  = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // [7:0] data_byte, [16:8] message_length
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [0] found, [8:1] port_number,
                                 // [16:9] payload_offset, [24:17] payload_length

  int mismatch_count;
  int pending_results;
  int results_checked;
  int payloads_found;

  logic [7:0] msg_bytes[$];      // message under construction
  int         bytes_sent  = 0;
  int         idle_odds   = 4;   // sender idles before a request with odds 1 in N, 0 = never
  bit         quiet_tail  = 1'b0;

  protobuf_data_field_extractor #(
    .MAX_MESSAGE_BYTES(MSG_MAX)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  pbx_result_checker #(
    .MAX_MESSAGE_BYTES(MSG_MAX)
  ) checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results),
    .results_checked(results_checked),
    .payloads_found (payloads_found)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang or a lost result ends here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding",
             cycles, pending_results);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle density changes now and then: none, heavy or light.
  function automatic int pick_idle_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 10;
    endcase
  endfunction

  // LEB128 encoding; pad > 0 stretches it with redundant continuation bytes.
  function automatic void put_varint(input logic [31:0] value, input int pad);
    logic [31:0] v;
    int          i;
    v = value;
    while (v > 32'd127) begin
      msg_bytes.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end
    if (pad == 0) begin
      msg_bytes.push_back({1'b0, v[6:0]});
    end else begin
      msg_bytes.push_back({1'b1, v[6:0]});
      for (i = 1; i < pad; i++) msg_bytes.push_back(8'h80);
      msg_bytes.push_back(8'h00);
    end
  endfunction

  function automatic int varint_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
  endfunction

  // Mostly well-formed message with random content. A big one carries a long payload
  // and is filled with random bytes up to the largest message size.
  function automatic void build_message(input bit big);
    int         fields;
    int         k;
    int         n;
    int         kind;
    logic [2:0] bad_wire[4];
    bad_wire = '{WIRE_GROUP_START, WIRE_GROUP_END, WIRE_RESERVED_6, WIRE_RESERVED_7};
    msg_bytes.delete();
    fields = big ? 3 : $urandom_range(1, 5);
    for (k = 0; k < fields; k++) begin
      kind = big ? k * 5 + (k == 2 ? 0 : 0) : $urandom_range(0, 19);
      if (kind < 5) begin
        msg_bytes.push_back({pbx_pkg::FIELD_PORT, pbx_pkg::WIRE_VARINT});
        put_varint($urandom >> $urandom_range(0, 31), varint_pad());
      end else if (kind < 10) begin
        n = big ? $urandom_range(128, 240) : $urandom_range(0, 12);
        msg_bytes.push_back({pbx_pkg::FIELD_PAYLOAD, pbx_pkg::WIRE_LEN});
        put_varint(n, varint_pad());
        repeat (n) msg_bytes.push_back(8'($urandom));
      end else if (kind < 13) begin
        msg_bytes.push_back({5'($urandom), pbx_pkg::WIRE_VARINT});
        put_varint($urandom >> $urandom_range(0, 31), varint_pad());
      end else if (kind < 15) begin
        n = $urandom_range(0, 10);
        msg_bytes.push_back({5'($urandom), pbx_pkg::WIRE_LEN});
        put_varint(n, varint_pad());
        repeat (n) msg_bytes.push_back(8'($urandom));
      end else if (kind < 17) begin
        msg_bytes.push_back({5'($urandom), pbx_pkg::WIRE_FIXED32});
        repeat (4) msg_bytes.push_back(8'($urandom));
      end else if (kind < 19) begin
        msg_bytes.push_back({5'($urandom), pbx_pkg::WIRE_FIXED64});
        repeat (8) msg_bytes.push_back(8'($urandom));
      end else begin
        msg_bytes.push_back({5'($urandom), bad_wire[$urandom_range(0, 3)]});
        repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
      end
    end
    if (big) while (msg_bytes.size() < MSG_MAX) msg_bytes.push_back(8'($urandom));
    while (msg_bytes.size() > MSG_MAX) void'(msg_bytes.pop_back());
  endfunction

  // One request; valid stays high from one request to the next unless an idle
  // burst comes in between.
  task automatic send_byte(input logic [7:0] b, input logic [8:0] msg_len);
    pbx_pkg::item_t req;
    if (!quiet_tail && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req.data_byte      = b;
    req.message_length = msg_len;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (bytes_sent % 64 == 0) idle_odds = pick_idle_odds();
    if (bytes_sent >= ITEM_TARGET - QUIET_TAIL) quiet_tail = 1'b1;
  endtask

  task automatic send_message(input logic [8:0] msg_len);
    int i;
    for (i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], msg_len);
  endtask

  // Receiver: random stall bursts, one long hold-off once results flow, and a
  // steady ready during the tail.
  initial begin : receiver
    int  odds;
    int  span;
    bit  pressure_done;
    odds          = 4;
    span          = 0;
    pressure_done = 1'b0;
    @(posedge clk);
    forever begin
      if (!pressure_done && results_checked >= 30) begin
        // sender keeps offering; the block must fill and drop in_tready
        out_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else if (!quiet_tail && odds != 0 && $urandom_range(1, odds) == 1) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (++span == 150) begin
        span = 0;
        odds = pick_idle_odds();
      end
    end
  end

  initial begin : stimulus
    int         shape;
    int         msg_index;
    int         cut;
    logic [8:0] big_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: port tag as the last byte (port reads 0), payload tag as the
    // last byte (nothing recorded), a plain port + payload message, a payload
    // length cut off at zero, a halting wire type, a fixed32 running past the
    // end, an over-long port varint, and a zero message length.
    msg_bytes = '{8'h08};
    send_message(9'd1);
    msg_bytes = '{8'h12};
    send_message(9'd1);
    msg_bytes = '{8'h08, 8'h96, 8'h01, 8'h12, 8'h01, 8'hAA};
    send_message(9'd6);
    msg_bytes = '{8'h12, 8'h80};
    send_message(9'd2);
    msg_bytes = '{8'h1B, 8'h12, 8'h00};
    send_message(9'd3);
    msg_bytes = '{8'h0D, 8'h01, 8'h02};
    send_message(9'd3);
    msg_bytes = '{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
    send_message(9'd12);
    msg_bytes = '{8'hFF};
    send_message(9'd0);

    // Random: mostly well-formed messages, some cut short or overrun, some noise.
    msg_index = 0;
    while (bytes_sent < ITEM_TARGET) begin
      shape = $urandom_range(0, 19);
      if (msg_index == 5 || msg_index == 25) begin
        // full-size messages; the second one claims a length past the maximum
        build_message(1'b1);
        big_len = (msg_index == 5) ? 9'(MSG_MAX) : 9'($urandom_range(MSG_MAX + 1, 511));
        send_message(big_len);
      end else if (shape < 15) begin
        build_message(1'b0);
        send_message(9'(msg_bytes.size()));
      end else if (shape < 17) begin
        build_message(1'b0);
        if ($urandom_range(0, 1)) begin
          cut = $urandom_range(1, msg_bytes.size());
          while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
        end else begin
          repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
        end
        send_message(9'(msg_bytes.size()));
      end else if (shape < 19) begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 24)) msg_bytes.push_back(8'($urandom));
        send_message(9'(msg_bytes.size()));
      end else begin
        // length field changing within a message; a length-1 byte re-aligns
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 9'($urandom_range(0, 511)));
        send_byte(8'($urandom), 9'd1);
      end
      msg_index++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d message bytes; %0d results compared, %0d with a payload located.",
             bytes_sent, results_checked, payloads_found);
    $display("Mix: tag/varint/length/fixed/halting fields, long and cut-off varints, odd lengths, %0d-cycle output hold-off.",
             PRESSURE_CYCLES);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pbx_pkg.sv
rtl/pbx_in_stage.sv
rtl/pbx_parser.sv
rtl/protobuf_data_field_extractor.sv
bench/pbx_result_checker.sv
bench/testbench.sv
